// ===== design/lphi_pkg.sv =====
// ----------------------------------------------------------------------------
// lphi_pkg
// Shared types and constants for the linear-probing hash insert core.
// ----------------------------------------------------------------------------
`default_nettype none

package lphi_pkg;

    localparam int KEY_W  = 32;
    localparam int NAME_W = 64;
    localparam int ENTRY_W = KEY_W + NAME_W;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_HOME   = 2'd0,
        STATUS_PROBED = 2'd1,
        STATUS_FULL   = 2'd2,
        STATUS_READ   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_PROBE,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name_tag;
        logic [3:0]        slot_index;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [3:0]        slot;
        logic              occupied;
        logic [KEY_W-1:0]  stored_key;
        logic [NAME_W-1:0] stored_name;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/lphi_ram.sv =====
// ----------------------------------------------------------------------------
// lphi_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lphi_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/linear_probe_hash_insert_core.sv =====
// Insert: accepted in IDLE, then passes REDUCE, PROBE and RESULT; the result is registered in RESULT.
// Read: skips REDUCE and passes PROBE and RESULT; either kind may be accepted again once back in IDLE.
// Insert adds the REDUCE state for the key modulo reduction (reciprocal multiply, then
// multiply-subtract); both kinds issue the registered read of the entry RAM in PROBE.
// One transaction in flight; a waiting result holds the block in its result state.
// Reset (sync, active low) clears all occupied flags at once; no clearing pass.
// ----------------------------------------------------------------------------
// linear_probe_hash_insert_core
// Open-addressing hash table with linear probing: insert records, read slots.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_insert_core #(
    parameter int SLOTS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire lphi_pkg::t_in_item   i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output lphi_pkg::t_out_item       o_out
);

    localparam int IW = $clog2(SLOTS);
    localparam int RW = IW + 5;
    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / SLOTS);
    localparam logic [31:0] SLOTS_W = 32'(SLOTS);

    // lowest set bit: {found, index}
    function automatic logic [IW:0] first_set(input logic [SLOTS-1:0] v);
        logic [IW:0] res;
        res = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = {1'b1, IW'(i)};
            end
        end
        return res;
    endfunction

    // 4-bit index modulo SLOTS; at most eight subtractions
    function automatic logic [IW-1:0] read_index(input logic [3:0] sidx);
        logic [RW-1:0] v;
        v = RW'(sidx);
        for (int k = 0; k < 8; k++) begin
            if (v >= RW'(SLOTS)) begin
                v = v - RW'(SLOTS);
            end
        end
        return v[IW-1:0];
    endfunction

    lphi_pkg::t_state    r_state, n_state;
    lphi_pkg::t_in_item  r_in;
    logic [63:0]         r_prod;
    logic [IW-1:0]       r_home;
    logic [SLOTS-1:0]    r_valid;
    lphi_pkg::t_status   r_res_status;
    logic [IW-1:0]       r_res_idx;
    logic                r_res_occ;
    logic                r_res_ram;
    lphi_pkg::t_out_item r_out, n_out;
    logic                r_out_valid;

    logic                accept;
    logic                ram_we, ram_re, load_out;
    logic [31:0]         qs, rem, rem_fix;
    logic [SLOTS-1:0]    free_vec, hi_mask;
    logic [IW:0]         pick_hi, pick_lo;
    logic [IW-1:0]       target;
    logic                any_free;
    logic [lphi_pkg::ENTRY_W-1:0] ram_q;
    logic [IW+3:0]       slot_ext;

    assign o_in_ready  = (r_state == lphi_pkg::ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // home slot: quotient estimate is low by at most one
    assign qs      = 32'(r_prod[63:32] * SLOTS_W);
    assign rem     = r_in.key - qs;
    assign rem_fix = (rem >= SLOTS_W) ? rem - SLOTS_W : rem;

    // find first free slot from home, wrapping
    always_comb begin
        free_vec = ~r_valid;
        for (int i = 0; i < SLOTS; i++) begin
            hi_mask[i] = (IW'(i) >= r_home);
        end
        pick_hi  = first_set(free_vec & hi_mask);
        pick_lo  = first_set(free_vec);
        any_free = pick_lo[IW];
        target   = pick_hi[IW] ? pick_hi[IW-1:0] : pick_lo[IW-1:0];
    end

    always_comb begin
        n_state  = r_state;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        load_out = 1'b0;
        case (r_state)
            lphi_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (i_in.kind == lphi_pkg::KIND_READ) ? lphi_pkg::ST_PROBE
                                                                 : lphi_pkg::ST_REDUCE;
                end
            end
            lphi_pkg::ST_REDUCE: begin
                n_state = lphi_pkg::ST_PROBE;
            end
            lphi_pkg::ST_PROBE: begin
                ram_re  = 1'b1;
                ram_we  = (r_in.kind == lphi_pkg::KIND_INSERT) && any_free;
                n_state = lphi_pkg::ST_RESULT;
            end
            lphi_pkg::ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = lphi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lphi_pkg::ST_IDLE;
            end
        endcase
    end

    // result assembly from staged status and RAM data
    always_comb begin
        slot_ext          = (IW + 4)'(r_res_idx);
        n_out.status      = r_res_status;
        n_out.slot        = slot_ext[3:0];
        n_out.occupied    = r_res_occ;
        if (r_res_ram) begin
            n_out.stored_key  = ram_q[lphi_pkg::ENTRY_W-1:lphi_pkg::NAME_W];
            n_out.stored_name = ram_q[lphi_pkg::NAME_W-1:0];
        end else if (r_res_occ) begin
            n_out.stored_key  = r_in.key;
            n_out.stored_name = r_in.name_tag;
        end else begin
            n_out.stored_key  = '0;
            n_out.stored_name = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lphi_pkg::ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_valid[target] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in   <= i_in;
            r_prod <= 64'(i_in.key) * 64'(RECIP);
            r_home <= read_index(i_in.slot_index);
        end
        if (r_state == lphi_pkg::ST_REDUCE) begin
            r_home <= rem_fix[IW-1:0];
        end
        if (r_state == lphi_pkg::ST_PROBE) begin
            if (r_in.kind == lphi_pkg::KIND_READ) begin
                r_res_status <= lphi_pkg::STATUS_READ;
                r_res_idx    <= r_home;
                r_res_occ    <= r_valid[r_home];
                r_res_ram    <= r_valid[r_home];
            end else if (any_free) begin
                r_res_status <= (target == r_home) ? lphi_pkg::STATUS_HOME
                                                   : lphi_pkg::STATUS_PROBED;
                r_res_idx    <= target;
                r_res_occ    <= 1'b1;
                r_res_ram    <= 1'b0;
            end else begin
                r_res_status <= lphi_pkg::STATUS_FULL;
                r_res_idx    <= r_home;
                r_res_occ    <= 1'b1;
                r_res_ram    <= 1'b1;
            end
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    lphi_ram #(
        .WIDTH (lphi_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (target),
        .i_wdata ({r_in.key, r_in.name_tag}),
        .i_re    (ram_re),
        .i_raddr (r_home),
        .o_rdata (ram_q)
    );

endmodule

`default_nettype wire

// ===== design/lphi_checker.sv =====
// ----------------------------------------------------------------------------
// lphi_checker
// Port-level assertions for the hash insert core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lphi_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire lphi_pkg::t_in_item  i_in,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire lphi_pkg::t_out_item o_out
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one transaction in flight: ready drops after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction accepted while busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

    // empty slot never exposes contents
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.occupied) |->
            (o_out.stored_key == '0 && o_out.stored_name == '0 &&
             o_out.status == lphi_pkg::STATUS_READ))
        else $error("empty slot with nonzero contents or non-read status");

    // a read accepted while no result waits passes PROBE and RESULT and must then
    // show on the ports with read status
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.kind == lphi_pkg::KIND_READ && !o_out_valid)
            |-> ##3 (o_out_valid && o_out.status == lphi_pkg::STATUS_READ))
        else $error("read result missing");

endmodule

bind linear_probe_hash_insert_core lphi_checker u_lphi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
